/* hdl/rtty_pkg.sv */
// ----------------------------------------------------------------------------
// RTTY sequencer package
// Shared codes, widths and types for the RTTY AFSK segment sequencer.
// ----------------------------------------------------------------------------
package rtty_pkg;

   // Number of Baudot data bits sent per character (5 to 8).
   localparam int DATA_BITS = 5;
   localparam int CODE_W = 5;
   localparam int PREAMBLE_STOPS = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int BIT_IDX_W = $clog2(DATA_BITS + 2);

   // Command modes on the request channel.
   localparam logic [1:0] MODE_CHAR = 2'd0;
   localparam logic [1:0] MODE_PREAMBLE = 2'd1;
   localparam logic [1:0] MODE_END = 2'd2;
   localparam logic [1:0] MODE_DIDDLE = 2'd3;

   localparam logic [CODE_W-1:0] DIDDLE_CODE = 5'h1f;

   // Command kinds after classification.
   localparam logic [1:0] KIND_CHAR = 2'd0;
   localparam logic [1:0] KIND_PREAMBLE = 2'd1;
   localparam logic [1:0] KIND_END = 2'd2;

   // Line bit history codes.
   localparam logic [1:0] BIT_SPACE = 2'd0;
   localparam logic [1:0] BIT_MARK = 2'd1;
   localparam logic [1:0] BIT_STOP = 2'd2;
   localparam logic [1:0] BIT_UNKNOWN = 2'd3;

   // Envelope codes.
   localparam logic [1:0] ENV_STEADY = 2'd0;
   localparam logic [1:0] ENV_RISE = 2'd1;
   localparam logic [1:0] ENV_FALL = 2'd2;

   typedef logic [DATA_BITS-1:0] data_type;

   typedef struct packed {
      logic [1:0] kind;
      data_type data;
   } cmd_type;

   typedef struct packed {
      logic tone;
      logic [1:0] envelope;
      logic last;
      logic error;
   } seg_type;

   // Space is sent on the space tone (1); mark and stop on the mark tone (0).
   function automatic logic tone_of(input logic [1:0] bit_code);
      tone_of = (bit_code == BIT_SPACE);
   endfunction

endpackage

/* hdl/rtty_front.sv */
// ----------------------------------------------------------------------------
// RTTY front end
// Decodes a request transfer into a queued command (kind plus data bits).
// ----------------------------------------------------------------------------
module rtty_front import rtty_pkg::*; (
   input  logic [1:0]        mode,
   input  logic [CODE_W-1:0] code,
   output cmd_type           cmd
);

   always_comb begin
      cmd.data = data_type'(code);
      case (mode)
         MODE_CHAR: begin
            cmd.kind = KIND_CHAR;
         end
         MODE_PREAMBLE: begin
            cmd.kind = KIND_PREAMBLE;
         end
         MODE_END: begin
            cmd.kind = KIND_END;
         end
         MODE_DIDDLE: begin
            cmd.kind = KIND_CHAR;
            cmd.data = data_type'(DIDDLE_CODE);
         end
         default: begin
            cmd.kind = KIND_CHAR;
         end
      endcase
   end

endmodule

/* hdl/rtty_queue.sv */
// ----------------------------------------------------------------------------
// RTTY command queue
// Small register FIFO that decouples command intake from segment output.
// ----------------------------------------------------------------------------
module rtty_queue import rtty_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   cmd_type slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic push, pop;

   assign push_ready = (count_ff != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* hdl/rtty_back.sv */
// ----------------------------------------------------------------------------
// RTTY segment sequencer back end
// Steps through the bits of one command and emits one half-bit segment per
// cycle, unless the receiver stalls, into a registered output stage.
// ----------------------------------------------------------------------------
module rtty_back import rtty_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    reverse,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd,
   output logic    seg_valid,
   input  logic    seg_ready,
   output seg_type seg
);

   logic                 busy_ff, busy_in;
   logic [1:0]           kind_ff, kind_in;
   data_type             data_ff, data_in;
   logic [BIT_IDX_W-1:0] idx_ff, idx_in;
   logic [1:0]           half_ff, half_in;
   logic [1:0]           prev_ff, prev_in;
   logic                 out_valid_ff, out_valid_in;
   seg_type              out_seg_ff, out_seg_in;

   logic       advance;
   logic [1:0] cur_bit;
   logic       cur_tone, prev_tone;
   logic       last_half, last_bit;
   seg_type    next_seg;

   assign advance   = !out_valid_ff || seg_ready;
   assign cmd_ready = !busy_ff;
   assign seg_valid = out_valid_ff;
   assign seg       = out_seg_ff;

   always_comb begin
      if (kind_ff == KIND_PREAMBLE) begin
         cur_bit = BIT_STOP;
      end else if (idx_ff == '0) begin
         cur_bit = BIT_SPACE;
      end else if (idx_ff == BIT_IDX_W'(DATA_BITS + 1)) begin
         cur_bit = BIT_STOP;
      end else begin
         cur_bit = data_ff[0] ? BIT_MARK : BIT_SPACE;
      end
      cur_tone  = tone_of(cur_bit);
      prev_tone = tone_of(prev_ff);
      last_half = (cur_bit == BIT_STOP) ? (half_ff == 2'd2) : (half_ff == 2'd1);
      if (kind_ff == KIND_PREAMBLE) begin
         last_bit = (idx_ff == BIT_IDX_W'(PREAMBLE_STOPS - 1));
      end else begin
         last_bit = (idx_ff == BIT_IDX_W'(DATA_BITS + 1));
      end
   end

   // Segment for the current half-bit. The first two halves depend on the
   // bit before: rise from silence, steady on the same tone, or fall and
   // rise on a tone change. The third half of a stop bit is always steady.
   always_comb begin
      next_seg.tone     = cur_tone ^ reverse;
      next_seg.envelope = ENV_STEADY;
      next_seg.last     = last_half && last_bit;
      next_seg.error    = 1'b0;
      if (half_ff == 2'd0) begin
         if (prev_ff == BIT_UNKNOWN) begin
            next_seg.envelope = ENV_RISE;
         end else if (prev_tone != cur_tone) begin
            next_seg.tone     = prev_tone ^ reverse;
            next_seg.envelope = ENV_FALL;
         end
      end else if (half_ff == 2'd1) begin
         if (prev_ff != BIT_UNKNOWN && prev_tone != cur_tone) begin
            next_seg.envelope = ENV_RISE;
         end
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      kind_in      = kind_ff;
      data_in      = data_ff;
      idx_in       = idx_ff;
      half_in      = half_ff;
      prev_in      = prev_ff;
      out_valid_in = out_valid_ff && !seg_ready;
      out_seg_in   = out_seg_ff;
      if (!busy_ff) begin
         if (cmd_valid) begin
            busy_in = 1'b1;
            kind_in = cmd.kind;
            data_in = cmd.data;
            idx_in  = '0;
            half_in = 2'd0;
         end
      end else if (advance) begin
         out_valid_in = 1'b1;
         if (kind_ff == KIND_END) begin
            busy_in = 1'b0;
            if (prev_ff == BIT_MARK || prev_ff == BIT_STOP) begin
               out_seg_in.tone     = reverse;
               out_seg_in.envelope = ENV_FALL;
               out_seg_in.last     = 1'b1;
               out_seg_in.error    = 1'b0;
               prev_in             = BIT_UNKNOWN;
            end else begin
               out_seg_in.tone     = 1'b0;
               out_seg_in.envelope = ENV_STEADY;
               out_seg_in.last     = 1'b1;
               out_seg_in.error    = 1'b1;
            end
         end else begin
            out_seg_in = next_seg;
            if (last_half) begin
               prev_in = cur_bit;
               half_in = 2'd0;
               idx_in  = idx_ff + 1'b1;
               if (kind_ff == KIND_CHAR && idx_ff != '0) begin
                  data_in = data_ff >> 1;
               end
               if (last_bit) begin
                  busy_in = 1'b0;
               end
            end else begin
               half_in = half_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         prev_ff      <= BIT_UNKNOWN;
         out_valid_ff <= 1'b0;
         kind_ff      <= KIND_CHAR;
         idx_ff       <= '0;
         half_ff      <= 2'd0;
      end else begin
         busy_ff      <= busy_in;
         prev_ff      <= prev_in;
         out_valid_ff <= out_valid_in;
         kind_ff      <= kind_in;
         idx_ff       <= idx_in;
         half_ff      <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff    <= data_in;
      out_seg_ff <= out_seg_in;
   end

endmodule

/* hdl/rtty_afsk_segment_sequencer.sv */
// ----------------------------------------------------------------------------
// RTTY AFSK segment sequencer
// Turns RTTY commands into a stream of half-bit waveform segment codes.
// ----------------------------------------------------------------------------
// Usage:
// The req_ channel takes one command per transfer: send a character, send
// a preamble of five stop bits, end the transmission, or send a diddle. The
// rsp_ channel returns one transfer per half-bit segment, giving the tone,
// the envelope (steady, rise or fall) and tlast on the final segment of the
// command. An end request after a space bit or from silence returns a single
// transfer with tuser set and no segment. The csr_ port writes the reverse
// bit, which swaps the mark and space tones; write it only while idle.
// A character, a diddle or a preamble yields 15 segments; the generator
// loads each command and then produces one segment per cycle unless the
// receiver stalls. The first segment passes the command queue, the
// generator load and the output register. A four-entry command queue sits
// between intake and the generator, so further requests are taken while
// segments are still being produced. When the receiver stalls, the output
// register holds its segment and the generator waits; requests keep being
// taken until the queue fills. Reset empties the queue, drops any pending
// segment, clears reverse and returns the line history to silence.
// ----------------------------------------------------------------------------
module rtty_afsk_segment_sequencer import rtty_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [1:0] mode, [6:2] code, [7] zero
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] tone, [2:1] envelope, [7:3] zero
   output logic       rsp_tlast,
   output logic [0:0] rsp_tuser,   // [0] error
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data
);

   logic    reverse_ff, reverse_in;
   cmd_type front_cmd;
   cmd_type queue_cmd;
   logic    queue_valid;
   logic    back_ready;
   seg_type out_seg;

   // The reverse register accepts a write on every cycle.
   assign csr_ready  = 1'b1;
   assign reverse_in = (csr_valid && csr_ready) ? csr_data : reverse_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         reverse_ff <= 1'b0;
      end else begin
         reverse_ff <= reverse_in;
      end
   end

   rtty_front u_front (
      .mode (req_tdata[1:0]),
      .code (req_tdata[6:2]),
      .cmd  (front_cmd)
   );

   rtty_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_tvalid),
      .push_ready (req_tready),
      .push_cmd   (front_cmd),
      .pop_valid  (queue_valid),
      .pop_ready  (back_ready),
      .pop_cmd    (queue_cmd)
   );

   rtty_back u_back (
      .clock     (clock),
      .reset     (reset),
      .reverse   (reverse_ff),
      .cmd_valid (queue_valid),
      .cmd_ready (back_ready),
      .cmd       (queue_cmd),
      .seg_valid (rsp_tvalid),
      .seg_ready (rsp_tready),
      .seg       (out_seg)
   );

   assign rsp_tdata = {5'b0, out_seg.envelope, out_seg.tone};
   assign rsp_tlast = out_seg.last;
   assign rsp_tuser = out_seg.error;

endmodule

/* hdl/rtty_checker.sv */
// ----------------------------------------------------------------------------
// RTTY sequencer checker
// Port-level checks on the segment stream, bound to the top level.
// ----------------------------------------------------------------------------
module rtty_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic [0:0] rsp_tuser
);

   // An error transfer is always the only, and so last, result and is empty.
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast && rsp_tdata == 8'd0)
      else $error("error transfer with segment content or without tlast");

   // The envelope never takes the unused code, and padding bits stay zero.
   a_env_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:1] != 2'b11 && rsp_tdata[7:3] == 5'd0)
      else $error("bad envelope code or padding");

   // Reset drops any pending segment.
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("segment pending after reset");

   // A stalled segment holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("segment changed under stall");

endmodule

bind rtty_afsk_segment_sequencer rtty_checker u_checker (.*);
